>>> rtl/jls_pkg.sv
package jls_pkg;

    localparam int DATA_W = 32;
    localparam int DIV_NUM_W = 48;
    localparam int MUL_W = 33;
    localparam int PROD_W = 2 * MUL_W;

    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

    // input item kinds
    localparam logic [1:0] KIND_MATRIX = 2'd0;
    localparam logic [1:0] KIND_RHS    = 2'd1;
    localparam logic [1:0] KIND_GUESS  = 2'd2;
    localparam logic [1:0] KIND_SOLVE  = 2'd3;

    // register indexes (8-byte stride)
    localparam logic [1:0] REG_SIZE = 2'd0;
    localparam logic [1:0] REG_MAXIT = 2'd1;
    localparam logic [1:0] REG_TOL = 2'd2;

    typedef struct packed {
        logic                          start;
        logic signed [DIV_NUM_W-1:0]   num;
        logic signed [DATA_W-1:0]      den;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [DATA_W-1:0] quot;
    } div_rsp_t;

    function automatic logic signed [DATA_W-1:0] sat_w50(input logic signed [49:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 50'(Q_MAX))
            r = Q_MAX;
        else if (v < 50'(Q_MIN))
            r = Q_MIN;
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_w33(input logic signed [32:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 33'(Q_MAX))
            r = Q_MAX;
        else if (v < 33'(Q_MIN))
            r = Q_MIN;
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

endpackage

>>> rtl/jls_ram.sv
module jls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/jls_mul.sv
module jls_mul (
    input  logic                               clk,
    input  logic signed [jls_pkg::MUL_W-1:0]   a,
    input  logic signed [jls_pkg::MUL_W-1:0]   b,
    output logic signed [jls_pkg::PROD_W-1:0]  p
);
    import jls_pkg::*;

    always_ff @(posedge clk)
    begin
        p <= a * b;
    end

endmodule

>>> rtl/jls_div.sv
module jls_div (
    input  logic               clk,
    input  logic               rst_n,
    input  jls_pkg::div_req_t  req,
    output jls_pkg::div_rsp_t  rsp
);
    import jls_pkg::*;

    logic [5:0]            cnt_reg;
    logic                  done_reg;
    logic                  neg_reg;
    logic [DATA_W-1:0]     ud_reg;
    logic [DATA_W-1:0]     rem_reg;
    logic [DIV_NUM_W-1:0]  qm_reg;

    logic [DATA_W:0]       trial;
    logic                  fit;
    logic [DIV_NUM_W:0]    qmag;

    assign trial = {rem_reg, qm_reg[DIV_NUM_W-1]};
    assign fit = trial >= {1'b0, ud_reg};
    assign qmag = {1'b0, qm_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                cnt_reg <= 6'(DIV_NUM_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                done_reg <= (cnt_reg == 6'd1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            neg_reg <= req.num[DIV_NUM_W-1] ^ req.den[DATA_W-1];
            ud_reg <= req.den[DATA_W-1] ? DATA_W'(-req.den) : DATA_W'(req.den);
            qm_reg <= req.num[DIV_NUM_W-1] ? DIV_NUM_W'(-req.num) : DIV_NUM_W'(req.num);
            rem_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= fit ? DATA_W'(trial - {1'b0, ud_reg}) : trial[DATA_W-1:0];
            qm_reg <= {qm_reg[DIV_NUM_W-2:0], fit};
        end
    end

    // truncated quotient, sign applied, then saturated
    always_comb
    begin
        rsp.done = done_reg;
        if (!neg_reg)
            rsp.quot = (qmag > (DIV_NUM_W+1)'(Q_MAX)) ? Q_MAX : qm_reg[DATA_W-1:0];
        else if (qmag > (DIV_NUM_W+1)'(49'h8000_0000))
            rsp.quot = Q_MIN;
        else
            rsp.quot = DATA_W'(-qmag);
    end

endmodule

>>> rtl/jacobi_linear_solver.sv
// Channel  | Ports                                      | Handshake
// ---------+--------------------------------------------+------------------------------
// input    | kind row col value                         | start & !busy
// result   | index solution last converged iterations   | result_valid, one cycle each
//          | zero_diagonal                              |
// config   | psel penable pwrite paddr pwdata prdata    | APB, pready tied high
//
// Load beats (matrix, rhs, guess) are written straight into the stores and busy stays low.
// A solve beat raises busy. Per sweep each row streams its products through the shared
// multiplier, fetches the diagonal, runs the serial divider (skipped on a zero diagonal)
// and squares its change; a copy pass and the stop check follow, then the vector goes out.
// Reset is asynchronous active low; stores are not cleared and must be loaded.
// The receiver cannot stall: results go out on consecutive cycles.
module jacobi_linear_solver #(
    parameter int MAX_SIZE = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  kind,
    input  logic [3:0]  row,
    input  logic [3:0]  col,
    input  logic signed [31:0] value,
    output logic        result_valid,
    output logic [3:0]  index,
    output logic signed [31:0] solution,
    output logic        last,
    output logic        converged,
    output logic [7:0]  iterations,
    output logic        zero_diagonal,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import jls_pkg::*;

    localparam int LIMIT_N = (MAX_SIZE < 16) ? MAX_SIZE : 16;
    localparam int IW = $clog2(LIMIT_N);
    localparam int AW = $clog2(MAX_SIZE);
    localparam int MDEPTH = MAX_SIZE * MAX_SIZE;
    localparam int MAW = $clog2(MDEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_RHS, S_RHSW, S_PROD, S_DRAIN, S_DIAG, S_DIAGW, S_DIV,
        S_SQ, S_NORM, S_COPY, S_COPYW, S_CHECK, S_OUT, S_OUTW
    } state_t;

    state_t state_reg;

    // configuration
    logic [4:0]  size_reg;
    logic [7:0]  maxit_reg;
    logic [62:0] tol_reg;

    // sequencer
    logic [IW-1:0] i_reg, j_reg, k_reg, ck_reg, ok_reg, nlast_reg;
    logic          v1_reg, v2_reg, cv_reg, ov_reg, ol_reg;
    logic [7:0]    sweeps_reg;
    logic          conv_reg, zero_reg;

    // datapath
    logic signed [DATA_W-1:0] s_reg, old_reg, xnew_reg;
    logic [63:0]              norm_reg;

    logic launch, row_ok, col_ok, conv_now;
    logic [IW-1:0] nlast_calc, jx, cur_idx;

    logic [MAW-1:0] a_waddr, a_raddr;
    logic           a_we;
    logic [DATA_W-1:0] a_q, rhs_q, cur_q, next_q;
    logic           rhs_we, cur_we, next_we;
    logic [AW-1:0]  cur_waddr, cur_raddr;
    logic [DATA_W-1:0] cur_wdata;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [32:0]       diff;
    logic signed [MUL_W-1:0]  absd;
    logic signed [DATA_W-1:0] term;
    logic [64:0]              norm_sum;

    div_req_t dreq;
    div_rsp_t drsp;

    assign pready = 1'b1;
    assign busy = (state_reg != S_IDLE);
    assign launch = start && !busy;
    assign row_ok = int'(row) < MAX_SIZE;
    assign col_ok = int'(col) < MAX_SIZE;
    assign conv_now = norm_reg <= {1'b0, tol_reg};

    always_comb
    begin
        if (size_reg == 5'd0)
            nlast_calc = '0;
        else if (int'(size_reg) > LIMIT_N)
            nlast_calc = IW'(LIMIT_N - 1);
        else
            nlast_calc = IW'(int'(size_reg) - 1);
    end

    // ---- stores ----
    assign a_we = launch && (kind == KIND_MATRIX) && row_ok && col_ok;
    assign a_waddr = MAW'(int'(row) * MAX_SIZE + int'(col));
    assign jx = (state_reg == S_DIAG) ? i_reg : j_reg;
    assign a_raddr = MAW'(int'(i_reg) * MAX_SIZE + int'(jx));

    jls_ram #(.WIDTH(DATA_W), .DEPTH(MDEPTH)) u_mat (
        .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(value),
        .raddr(a_raddr), .rdata(a_q)
    );

    assign rhs_we = launch && (kind == KIND_RHS) && row_ok;

    jls_ram #(.WIDTH(DATA_W), .DEPTH(MAX_SIZE)) u_rhs (
        .clk(clk), .we(rhs_we), .waddr(AW'(row)), .wdata(value),
        .raddr(AW'(i_reg)), .rdata(rhs_q)
    );

    // current vector: loaded by guess beats, refreshed by the copy pass
    assign cur_we = cv_reg || (launch && (kind == KIND_GUESS) && row_ok);
    assign cur_waddr = cv_reg ? AW'(ck_reg) : AW'(row);
    assign cur_wdata = cv_reg ? next_q : value;

    always_comb
    begin
        if (state_reg == S_OUT)
            cur_idx = k_reg;
        else if (state_reg == S_DIAG)
            cur_idx = i_reg;
        else
            cur_idx = j_reg;
    end
    assign cur_raddr = AW'(cur_idx);

    jls_ram #(.WIDTH(DATA_W), .DEPTH(MAX_SIZE)) u_cur (
        .clk(clk), .we(cur_we), .waddr(cur_waddr), .wdata(cur_wdata),
        .raddr(cur_raddr), .rdata(cur_q)
    );

    assign next_we = (state_reg == S_SQ);

    jls_ram #(.WIDTH(DATA_W), .DEPTH(MAX_SIZE)) u_next (
        .clk(clk), .we(next_we), .waddr(AW'(i_reg)), .wdata(xnew_reg),
        .raddr(AW'(k_reg)), .rdata(next_q)
    );

    // ---- shared multiplier: A*x products, then the squared change ----
    assign diff = 33'(xnew_reg) - 33'(old_reg);
    assign absd = diff[32] ? -diff : diff;

    always_comb
    begin
        if (state_reg == S_SQ)
        begin
            mul_a = absd;
            mul_b = absd;
        end
        else
        begin
            mul_a = MUL_W'(signed'(a_q));
            mul_b = MUL_W'(signed'(cur_q));
        end
    end

    jls_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));

    // floor shift is an arithmetic shift
    assign term = sat_w50(prod[65:16]);
    assign norm_sum = {1'b0, norm_reg} + {1'b0, prod[63:0]};

    // ---- divider ----
    assign dreq.start = (state_reg == S_DIAGW) && (a_q != '0);
    assign dreq.num = {s_reg, 16'b0};
    assign dreq.den = a_q;

    jls_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    // ---- sequencer and registered outputs ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            size_reg <= 5'd4;
            maxit_reg <= 8'd100;
            tol_reg <= 63'd1;
            i_reg <= '0;
            j_reg <= '0;
            k_reg <= '0;
            ck_reg <= '0;
            ok_reg <= '0;
            nlast_reg <= '0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            cv_reg <= 1'b0;
            ov_reg <= 1'b0;
            ol_reg <= 1'b0;
            sweeps_reg <= '0;
            conv_reg <= 1'b0;
            zero_reg <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite)
            begin
                unique case (paddr[4:3])
                    REG_SIZE:  size_reg <= pwdata[4:0];
                    REG_MAXIT: maxit_reg <= pwdata[7:0];
                    REG_TOL:   tol_reg <= pwdata[62:0];
                    default:   ;
                endcase
            end

            v1_reg <= 1'b0;
            v2_reg <= v1_reg;
            cv_reg <= 1'b0;
            ov_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (launch && (kind == KIND_SOLVE))
                    begin
                        nlast_reg <= nlast_calc;
                        sweeps_reg <= '0;
                        conv_reg <= 1'b0;
                        zero_reg <= 1'b0;
                        i_reg <= '0;
                        k_reg <= '0;
                        state_reg <= (maxit_reg == 8'd0) ? S_OUT : S_RHS;
                    end
                end
                S_RHS:
                begin
                    j_reg <= '0;
                    state_reg <= S_RHSW;
                end
                S_RHSW:
                    state_reg <= S_PROD;
                S_PROD:
                begin
                    v1_reg <= (j_reg != i_reg);
                    if (j_reg == nlast_reg)
                        state_reg <= S_DRAIN;
                    else
                        j_reg <= j_reg + 1'b1;
                end
                S_DRAIN:
                begin
                    if (!v1_reg && !v2_reg)
                        state_reg <= S_DIAG;
                end
                S_DIAG:
                    state_reg <= S_DIAGW;
                S_DIAGW:
                begin
                    if (a_q == '0)
                    begin
                        zero_reg <= 1'b1;
                        state_reg <= S_SQ;
                    end
                    else
                        state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (drsp.done)
                        state_reg <= S_SQ;
                end
                S_SQ:
                    state_reg <= S_NORM;
                S_NORM:
                begin
                    if (i_reg == nlast_reg)
                    begin
                        k_reg <= '0;
                        state_reg <= S_COPY;
                    end
                    else
                    begin
                        i_reg <= i_reg + 1'b1;
                        state_reg <= S_RHS;
                    end
                end
                S_COPY:
                begin
                    cv_reg <= 1'b1;
                    ck_reg <= k_reg;
                    if (k_reg == nlast_reg)
                        state_reg <= S_COPYW;
                    else
                        k_reg <= k_reg + 1'b1;
                end
                S_COPYW:
                    state_reg <= S_CHECK;
                S_CHECK:
                begin
                    sweeps_reg <= sweeps_reg + 8'd1;
                    conv_reg <= conv_now;
                    i_reg <= '0;
                    k_reg <= '0;
                    if (conv_now || (sweeps_reg + 8'd1 == maxit_reg))
                        state_reg <= S_OUT;
                    else
                        state_reg <= S_RHS;
                end
                S_OUT:
                begin
                    ov_reg <= 1'b1;
                    ok_reg <= k_reg;
                    ol_reg <= (k_reg == nlast_reg);
                    if (k_reg == nlast_reg)
                        state_reg <= S_OUTW;
                    else
                        k_reg <= k_reg + 1'b1;
                end
                S_OUTW:
                    state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // ---- datapath registers ----
    always_ff @(posedge clk)
    begin
        if (state_reg == S_RHSW)
            s_reg <= rhs_q;
        else if (v2_reg)
            s_reg <= sat_w33(33'(s_reg) - 33'(term));

        if (state_reg == S_DIAGW)
        begin
            old_reg <= cur_q;
            if (a_q == '0)
                xnew_reg <= s_reg[DATA_W-1] ? Q_MIN : ((s_reg == '0) ? '0 : Q_MAX);
        end
        else if ((state_reg == S_DIV) && drsp.done)
            xnew_reg <= drsp.quot;

        if ((state_reg == S_RHS) && (i_reg == '0))
            norm_reg <= '0;
        else if (state_reg == S_NORM)
            norm_reg <= norm_sum[64] ? '1 : norm_sum[63:0];
    end

    // ---- result beat and register read-back ----
    assign result_valid = ov_reg;
    assign index = 4'(ok_reg);
    assign solution = cur_q;
    assign last = ol_reg;
    assign converged = conv_reg;
    assign iterations = sweeps_reg;
    assign zero_diagonal = zero_reg;

    always_comb
    begin
        unique case (paddr[4:3])
            REG_SIZE:  prdata = {59'b0, size_reg};
            REG_MAXIT: prdata = {56'b0, maxit_reg};
            REG_TOL:   prdata = {1'b0, tol_reg};
            default:   prdata = '0;
        endcase
    end

endmodule

>>> verif/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import jls_pkg::*;

    // Solution beat as the solver is predicted to emit it.
    typedef struct {
        logic [3:0]         index;
        logic signed [31:0] solution;
        logic               last;
        logic               converged;
        logic [7:0]         iterations;
        logic               zero_diagonal;
    } sol_beat_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  kind;
    logic [3:0]  row;
    logic [3:0]  col;
    logic signed [31:0] value;
    logic        result_valid;
    logic [3:0]  index;
    logic signed [31:0] solution;
    logic        last;
    logic        converged;
    logic [7:0]  iterations;
    logic        zero_diagonal;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    jacobi_linear_solver uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .kind(kind), .row(row), .col(col), .value(value),
        .result_valid(result_valid), .index(index), .solution(solution),
        .last(last), .converged(converged), .iterations(iterations),
        .zero_diagonal(zero_diagonal),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // 8 ns clock
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the solver: stores and register settings.
    // ------------------------------------------------------------------
    logic signed [31:0] sh_matrix [256];
    logic signed [31:0] sh_rhs    [16];
    logic signed [31:0] sh_x      [16];
    logic signed [31:0] sh_xnext  [16];
    logic [4:0]  sh_size;
    logic [7:0]  sh_maxit;
    logic [62:0] sh_tol;

    sol_beat_t pending_solution[$];
    int mismatches;

    function automatic longint clamp_q(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Run the Jacobi sweeps of one solve beat and queue the output vector.
    task automatic jacobi_solve_expect();
        int n;
        int sweeps;
        bit hit_zero;
        bit done;
        longint s;
        longint p;
        longint d;
        longint dd;
        logic [63:0] mag;
        logic [63:0] sq;
        logic [63:0] norm;
        logic [64:0] acc;
        sol_beat_t b;
        n = (sh_size == 0) ? 1 : ((sh_size > 16) ? 16 : int'(sh_size));
        sweeps = 0;
        hit_zero = 1'b0;
        done = 1'b0;
        while (!done && sweeps < int'(sh_maxit))
        begin
            norm = '0;
            for (int i = 0; i < n; i++)
            begin
                s = longint'(sh_rhs[i]);
                for (int j = 0; j < n; j++)
                begin
                    if (j != i)
                    begin
                        p = longint'(sh_matrix[i*16+j]) * longint'(sh_x[j]);
                        s = clamp_q(s - clamp_q(p >>> 16));
                    end
                end
                d = longint'(sh_matrix[i*16+i]);
                if (d == 0)
                begin
                    hit_zero = 1'b1;
                    sh_xnext[i] = (s > 0) ? Q_MAX : ((s < 0) ? Q_MIN : 32'sd0);
                end
                else
                    sh_xnext[i] = 32'(clamp_q((s * 65536) / d));
            end
            for (int i = 0; i < n; i++)
            begin
                dd = longint'(sh_xnext[i]) - longint'(sh_x[i]);
                mag = (dd < 0) ? 64'(-dd) : 64'(dd);
                sq = mag * mag;
                acc = {1'b0, norm} + {1'b0, sq};
                norm = acc[64] ? '1 : acc[63:0];
                sh_x[i] = sh_xnext[i];
            end
            done = (norm <= {1'b0, sh_tol});
            sweeps++;
        end
        for (int i = 0; i < n; i++)
        begin
            b.index = 4'(i);
            b.solution = sh_x[i];
            b.last = (i == n - 1);
            b.converged = done;
            b.iterations = 8'(sweeps);
            b.zero_diagonal = hit_zero;
            pending_solution.push_back(b);
        end
    endtask

    // ------------------------------------------------------------------
    // Input side. The beat is accepted at the edge where start & !busy;
    // start is left high so a back-to-back beat needs no second update.
    // ------------------------------------------------------------------
    task automatic send_beat(input logic [1:0] k, input logic [3:0] r,
                             input logic [3:0] c, input logic [31:0] v);
        int gap;
        gap = $urandom_range(0, 5);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        kind  <= k;
        row   <= r;
        col   <= c;
        value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        case (k)
            KIND_MATRIX: sh_matrix[r*16+c] = v;
            KIND_RHS:    sh_rhs[r] = v;
            KIND_GUESS:  sh_x[r] = v;
            default:     jacobi_solve_expect();
        endcase
    endtask

    // Stop sending and wait for every predicted beat, then let the
    // solver settle before touching registers.
    task automatic drain();
        start <= 1'b0;
        while (pending_solution.size() != 0 || busy)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // APB write: setup then access; pready is tied high.
    task automatic reg_write(input logic [1:0] idx, input logic [63:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(idx) << 3;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SIZE:  sh_size  = data[4:0];
            REG_MAXIT: sh_maxit = data[7:0];
            default:   sh_tol   = data[62:0];
        endcase
    endtask

    task automatic set_config(input logic [4:0] sz, input logic [7:0] it,
                              input logic [62:0] tol);
        reg_write(REG_SIZE, 64'(sz));
        reg_write(REG_MAXIT, 64'(it));
        reg_write(REG_TOL, 64'(tol));
    endtask

    // Diagonally dominant entry: large on the diagonal, small elsewhere.
    function automatic logic [31:0] well_posed(input int r, input int c);
        if (r == c)
            return 32'(($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(20, 40)) * 65536);
        return 32'(int'($urandom_range(0, 131072)) - 65536);
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every strobe is matched with the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        sol_beat_t e;
        if (rst_n && result_valid)
        begin
            if (pending_solution.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected solution beat: index %0d solution %h",
                             index, solution);
            end
            else
            begin
                e = pending_solution.pop_front();
                if (index !== e.index || solution !== e.solution || last !== e.last ||
                    converged !== e.converged || iterations !== e.iterations ||
                    zero_diagonal !== e.zero_diagonal)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp idx %0d sol %h last %b conv %b it %0d zd %b / got idx %0d sol %h last %b conv %b it %0d zd %b",
                                 e.index, e.solution, e.last, e.converged,
                                 e.iterations, e.zero_diagonal, index, solution,
                                 last, converged, iterations, zero_diagonal);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // The leading 4x4 block and the first four vector entries are written
    // before any solve; every solve keeps its size at four or below.
    task automatic test_fill_stores();
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                send_beat(KIND_MATRIX, 4'(r), 4'(c), well_posed(r, c));
        for (int r = 0; r < 4; r++)
        begin
            send_beat(KIND_RHS, 4'(r), 4'd0, $urandom());
            send_beat(KIND_GUESS, 4'(r), 4'd15, 32'(int'($urandom_range(0, 262144)) - 131072));
        end
    endtask

    // Reset settings, then the corner cases one by one.
    task automatic test_directed();
        send_beat(KIND_SOLVE, 4'd0, 4'd0, 32'd0);
        send_beat(KIND_SOLVE, 4'd15, 4'd15, 32'hffff_ffff);   // repeated solve
        drain();
        // zero iteration limit: vector goes out untouched
        set_config(5'd4, 8'd0, 63'd1);
        send_beat(KIND_SOLVE, 4'd0, 4'd0, 32'd0);
        drain();
        // size zero acts as one, long limit, tolerance zero
        set_config(5'd0, 8'd255, 63'd0);
        send_beat(KIND_SOLVE, 4'd0, 4'd0, 32'd0);
        drain();
        // huge tolerance stops after the first sweep
        set_config(5'd4, 8'd2, 63'h7fff_ffff_ffff_ffff);
        send_beat(KIND_SOLVE, 4'd0, 4'd0, 32'd0);
        drain();
        set_config(5'd2, 8'd1, 63'd0);
        send_beat(KIND_SOLVE, 4'd0, 4'd0, 32'd0);
        drain();
        // zero diagonal and extreme operands saturate products and quotients
        set_config(5'd3, 8'd3, 63'd1);
        send_beat(KIND_MATRIX, 4'd1, 4'd1, 32'd0);
        send_beat(KIND_MATRIX, 4'd0, 4'd1, 32'h8000_0000);
        send_beat(KIND_MATRIX, 4'd0, 4'd2, 32'h7fff_ffff);
        send_beat(KIND_RHS, 4'd1, 4'd0, 32'h7fff_ffff);
        send_beat(KIND_RHS, 4'd2, 4'd0, 32'h8000_0000);
        send_beat(KIND_GUESS, 4'd0, 4'd0, 32'h7fff_ffff);
        send_beat(KIND_GUESS, 4'd2, 4'd0, 32'h8000_0000);
        send_beat(KIND_SOLVE, 4'd0, 4'd0, 32'd0);
        send_beat(KIND_RHS, 4'd1, 4'd0, 32'd0);
        send_beat(KIND_GUESS, 4'd1, 4'd0, 32'd0);
        send_beat(KIND_SOLVE, 4'd0, 4'd0, 32'd0);          // zero over zero
        send_beat(KIND_RHS, 4'd1, 4'd0, 32'h8000_0000);
        send_beat(KIND_SOLVE, 4'd0, 4'd0, 32'd0);          // negative over zero
        // restore a usable diagonal
        send_beat(KIND_MATRIX, 4'd1, 4'd1, 32'h0020_0000);
        send_beat(KIND_MATRIX, 4'd0, 4'd1, 32'h0000_8000);
        send_beat(KIND_MATRIX, 4'd0, 4'd2, 32'hffff_8000);
        drain();
    endtask

    // Random phases: mostly in-range loads with random content and solves,
    // a few loads anywhere and full-width values for bit coverage.
    task automatic test_random();
        int n;
        int pick;
        logic [31:0] v;
        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase == 5)
                set_config(5'($urandom_range(1, 4)), 8'($urandom_range(1, 2)),
                           63'({$urandom(), $urandom()}));
            else
                set_config(5'($urandom_range(0, 4)), 8'($urandom_range(0, 12)),
                           63'($urandom_range(0, 1)) ? 63'($urandom_range(0, 65536))
                                                     : 63'({$urandom(), $urandom()}));
            n = (sh_size == 0) ? 1 : ((sh_size > 16) ? 16 : int'(sh_size));
            for (int k = 0; k < 10; k++)
            begin
                pick = $urandom_range(0, 9);
                v = ($urandom_range(0, 3) == 0) ? $urandom() : 32'(int'($urandom_range(0, 524288)) - 262144);
                if (pick < 2)
                    send_beat(KIND_SOLVE, 4'($urandom()), 4'($urandom()), $urandom());
                else if (pick < 5)
                begin
                    pick = $urandom_range(0, n - 1);
                    send_beat(KIND_MATRIX, 4'(pick), 4'(pick), well_posed(0, 0));
                end
                else if (pick < 7)
                    send_beat(KIND_MATRIX, 4'($urandom_range(0, n - 1)),
                              4'($urandom_range(0, n - 1)), well_posed(0, 1));
                else if (pick < 8)
                    send_beat(KIND_RHS, 4'($urandom_range(0, n - 1)), 4'($urandom()), v);
                else if (pick < 9)
                    send_beat(KIND_GUESS, 4'($urandom_range(0, n - 1)), 4'($urandom()), v);
                else
                    send_beat(2'($urandom_range(0, 2)), 4'($urandom()), 4'($urandom()), v);
            end
            send_beat(KIND_SOLVE, 4'd0, 4'd0, 32'd0);
            drain();   // sender holds off until every beat has come back
        end
    endtask

    initial
    begin
        mismatches = 0;
        rst_n   = 1'b0;
        start   = 1'b0;
        kind    = KIND_MATRIX;
        row     = '0;
        col     = '0;
        value   = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        sh_size  = 5'd4;
        sh_maxit = 8'd100;
        sh_tol   = 63'd1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fill_stores();
        test_directed();
        test_random();
        drain();

        if (mismatches == 0 && pending_solution.size() == 0)
            $display("** jacobi_linear_solver: PASSED **");
        else
            $display("** jacobi_linear_solver: FAILED **");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial
    begin
        #40ms;
        $display("** jacobi_linear_solver: FAILED **");
        $finish;
    end

endmodule

>>> filelist.f
rtl/jls_pkg.sv
rtl/jls_ram.sv
rtl/jls_mul.sv
rtl/jls_div.sv
rtl/jacobi_linear_solver.sv
verif/testbench.sv
